// ===== rtl/tpz_pkg.sv =====
// Package for the torus point z-buffer plotter: shared constants, types,
// the quarter-wave sine evaluator and the shade ramp. No dependencies.
`default_nettype none
package tpz_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 80;
  localparam int unsigned SCREEN_HEIGHT_DEF = 22;
  localparam int unsigned PHASE_BITS_DEF    = 10;

  localparam int unsigned FIELD_PHASE_W = 10;
  localparam int unsigned FIELD_INDEX_W = 11;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned DEPTH_W       = 16;
  localparam int unsigned GLYPH_W       = 7;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PLOT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_A = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_B = 2'd1;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;

  localparam longint unsigned POLY_A = 64'd1686629713;
  localparam longint unsigned POLY_B = 64'd688904866;
  localparam longint unsigned POLY_C = 64'd76016977;

  // Sine and cosine in Q1.14, intermediate values of the point math
  typedef logic signed [15:0] sin_t;
  typedef logic signed [19:0] val_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_start;
  } frame_ctl_t;

  // Quarter-wave sine, u in 0..4096 covers 0..pi/2, result in Q14
  function automatic logic [14:0] quarter_sine(input logic [12:0] u);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned inner;
    longint unsigned mid;
    longint unsigned s;
    longint unsigned r;
    z     = 64'(u) << 18;
    z2    = (z * z) >> 30;
    inner = POLY_B - ((z2 * POLY_C) >> 30);
    mid   = POLY_A - ((z2 * inner) >> 30);
    s     = (z * mid) >> 30;
    r     = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return r[14:0];
  endfunction

  // Shade ramp from dim to bright
  function automatic logic [GLYPH_W-1:0] shade_glyph(input logic [3:0] n);
    logic [GLYPH_W-1:0] g;
    case (n)
      4'd0:    g = 7'h2e;
      4'd1:    g = 7'h2c;
      4'd2:    g = 7'h2d;
      4'd3:    g = 7'h7e;
      4'd4:    g = 7'h3a;
      4'd5:    g = 7'h3b;
      4'd6:    g = 7'h3d;
      4'd7:    g = 7'h21;
      4'd8:    g = 7'h2a;
      4'd9:    g = 7'h23;
      4'd10:   g = 7'h24;
      default: g = 7'h40;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tpz_ifs.sv =====
// Channel interfaces of the plotter: input items, result items, config writes.
// Depends on nothing.
`default_nettype none
interface tpz_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  tube_phase;
  logic [9:0]  ring_phase;
  logic [10:0] read_index;
  modport source (output valid, operation, tube_phase, ring_phase, read_index, input ready);
  modport sink   (input valid, operation, tube_phase, ring_phase, read_index, output ready);
endinterface

interface tpz_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_index;
  logic [6:0]  glyph;
  logic        plotted;
  logic [15:0] depth_value;
  modport source (output valid, pixel_index, glyph, plotted, depth_value, input ready);
  modport sink   (input valid, pixel_index, glyph, plotted, depth_value, output ready);
endinterface

interface tpz_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tpz_trig.sv =====
// Sine lookup: quarter-wave constant table with quadrant folding.
// Depends on tpz_pkg (quarter_sine, sin_t).
`default_nettype none
module tpz_trig import tpz_pkg::*; #(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
  input  wire logic [PHASE_BITS-1:0] phase_i,
  output sin_t                       value_o
);
  localparam int unsigned QUART = 1 << (PHASE_BITS - 2);
  localparam int unsigned SHIFT = 14 - PHASE_BITS;

  logic [14:0]           rom_w [QUART+1];
  logic [1:0]            quad;
  logic [PHASE_BITS-3:0] rem;
  logic [PHASE_BITS-2:0] idx;
  logic [14:0]           mag;

  // Build the table at elaboration
  for (genvar g = 0; g <= QUART; g++) begin : g_rom
    assign rom_w[g] = quarter_sine(13'(g << SHIFT));
  end

  // Fold the phase into the first quadrant and restore the sign
  always_comb begin
    quad = phase_i[PHASE_BITS-1 -: 2];
    rem  = phase_i[PHASE_BITS-3:0];
    idx  = quad[0] ? ((PHASE_BITS-1)'(QUART) - {1'b0, rem}) : {1'b0, rem};
    mag  = rom_w[idx];
    value_o = quad[1] ? -sin_t'({1'b0, mag}) : sin_t'({1'b0, mag});
  end
endmodule
`default_nettype wire

// ===== rtl/tpz_mul.sv =====
// Shared signed multiplier with registered product and Q14 scaling.
// Depends on tpz_pkg (val_t).
`default_nettype none
module tpz_mul import tpz_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic signed [26:0] a_i,
  input  wire logic signed [26:0] b_i,
  output logic signed [53:0]      full_o,
  output val_t                    scaled_o
);
  logic signed [53:0] prod_q;
  logic signed [53:0] biased;

  // Register every product
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Divide by 2^14 truncating toward zero
  always_comb begin
    biased   = prod_q + (prod_q[53] ? 54'sd16383 : 54'sd0);
    full_o   = prod_q;
    scaled_o = val_t'(biased >>> 14);
  end
endmodule
`default_nettype wire

// ===== rtl/tpz_frame.sv =====
// Frame stores: depth and glyph memories with one read and one write port,
// plus the clearing sweep. Depends on tpz_pkg (frame_ctl_t, GLYPH_SPACE).
`default_nettype none
module tpz_frame import tpz_pkg::*; #(
  parameter int unsigned PIX_COUNT = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF,
  parameter int unsigned ADDR_W    = $clog2(PIX_COUNT)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire frame_ctl_t         ctl_i,
  input  wire logic [ADDR_W-1:0]  addr_i,
  input  wire logic [DEPTH_W-1:0] wr_depth_i,
  input  wire logic [GLYPH_W-1:0] wr_glyph_i,
  output logic [DEPTH_W-1:0]      rd_depth_o,
  output logic [GLYPH_W-1:0]      rd_glyph_o,
  output logic                    busy_o
);
  logic [DEPTH_W-1:0] depth_mem [PIX_COUNT];
  logic [GLYPH_W-1:0] glyph_mem [PIX_COUNT];
  logic [ADDR_W-1:0]  clr_cnt_q;
  logic               busy_q;

  // Sweep the stores after reset and on request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (ctl_i.clr_start) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      if (clr_cnt_q == ADDR_W'(PIX_COUNT - 1)) busy_q <= 1'b0;
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Memory ports, read data registered
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      depth_mem[clr_cnt_q] <= '0;
      glyph_mem[clr_cnt_q] <= GLYPH_SPACE;
    end else if (ctl_i.wr_en) begin
      depth_mem[addr_i] <= wr_depth_i;
      glyph_mem[addr_i] <= wr_glyph_i;
    end
    if (ctl_i.rd_en) begin
      rd_depth_o <= depth_mem[addr_i];
      rd_glyph_o <= glyph_mem[addr_i];
    end
  end

  assign busy_o = busy_q;
endmodule
`default_nettype wire

// ===== rtl/torus_point_zbuffer_plotter_top.sv =====
// Top level of the torus point z-buffer plotter: sequencer, reciprocal,
// config registers and result register. Depends on tpz_pkg, tpz_ifs,
// tpz_trig, tpz_mul and tpz_frame.
//
//   channel  dir  beat contents
//   in_i     in   operation, tube_phase, ring_phase, read_index
//   out_o    out  pixel_index, glyph, plotted, depth_value
//   cfg_i    in   index (0 angle_a, 1 angle_b), data
//
// A plot goes, from the input beat to a valid result, through 8 table
// lookups, 20 passes through the shared multiplier, 16 restoring divide
// steps for the inverse depth (skipped when it saturates), then a store
// read and compare when the point is on screen. A read does a store read
// when the index is in range; a clear waits for the store sweep. A new beat
// is taken only once the sequencer is back in idle. After reset the same
// sweep runs with in_i.ready low. Config beats are always taken. A new input
// beat is taken while a result waits on out_o; the next result holds until
// out_o drains.
`default_nettype none
module torus_point_zbuffer_plotter_top import tpz_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int unsigned PHASE_BITS    = PHASE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpz_in_if.sink    in_i,
  tpz_out_if.source out_o,
  tpz_cfg_if.sink   cfg_i
);
  localparam int unsigned PIX_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W    = $clog2(PIX_COUNT);
  localparam int unsigned QUART     = 1 << (PHASE_BITS - 2);
  localparam logic signed [55:0] X_BIAS = 56'(SCREEN_WIDTH / 2) <<< 30;
  localparam logic signed [55:0] Y_BIAS = 56'(SCREEN_HEIGHT / 2) <<< 30;

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLEAR  = 4'd1;
  localparam logic [3:0] ST_TRIG   = 4'd2;
  localparam logic [3:0] ST_MISS   = 4'd3;
  localparam logic [3:0] ST_MWB    = 4'd4;
  localparam logic [3:0] ST_DIVSET = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_POS    = 4'd7;
  localparam logic [3:0] ST_ADDR   = 4'd8;
  localparam logic [3:0] ST_RDREQ  = 4'd9;
  localparam logic [3:0] ST_CMP    = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  // Multiplier program steps
  localparam logic [4:0] MS_SICJ2 = 5'd0;
  localparam logic [4:0] MS_CICJ2 = 5'd1;
  localparam logic [4:0] MS_D1    = 5'd2;
  localparam logic [4:0] MS_D2    = 5'd3;
  localparam logic [4:0] MS_T1    = 5'd4;
  localparam logic [4:0] MS_T2    = 5'd5;
  localparam logic [4:0] MS_X1    = 5'd6;
  localparam logic [4:0] MS_X2    = 5'd7;
  localparam logic [4:0] MS_Y1    = 5'd8;
  localparam logic [4:0] MS_Y2    = 5'd9;
  localparam logic [4:0] MS_SICJ  = 5'd10;
  localparam logic [4:0] MS_CICJ  = 5'd11;
  localparam logic [4:0] MS_U     = 5'd12;
  localparam logic [4:0] MS_L1    = 5'd13;
  localparam logic [4:0] MS_L2    = 5'd14;
  localparam logic [4:0] MS_L3    = 5'd15;
  localparam logic [4:0] MS_XW    = 5'd16;
  localparam logic [4:0] MS_XP    = 5'd17;
  localparam logic [4:0] MS_YW    = 5'd18;
  localparam logic [4:0] MS_YP    = 5'd19;

  logic [3:0] state_q;
  logic [4:0] step_q;
  logic [2:0] kcnt_q;
  logic [3:0] div_cnt_q;

  logic [1:0]  op_q;
  logic [9:0]  tube_q, ring_q;
  logic [9:0]  angle_a_q, angle_b_q;

  sin_t trig_q [8];
  val_t sicj2_q, cicj2_q, dacc_q, p2_q, tacc_q, p4_q, xacc_q, yacc_q;
  val_t sicj_q, cicj_q, uacc_q, lacc_q;
  logic signed [26:0] xw_q, yw_q;
  logic signed [53:0] xprod_q, yprod_q;
  logic [19:0] rem_q, dvs_q;
  logic [15:0] depth_q;
  logic signed [25:0] x_q, y_q;
  logic [ADDR_W-1:0] addr_q;
  logic [6:0] shade_q;

  logic [10:0] res_pix_q;
  logic [6:0]  res_gl_q;
  logic        res_hit_q;
  logic [15:0] res_dep_q;

  logic        out_valid_q;
  logic [10:0] out_pix_q;
  logic [6:0]  out_gl_q;
  logic        out_hit_q;
  logic [15:0] out_dep_q;

  // Named trig values
  sin_t sj, cj, si, ci, s_a, c_a, s_b, c_b;
  val_t cj2;
  assign sj  = trig_q[0];
  assign cj  = trig_q[1];
  assign si  = trig_q[2];
  assign ci  = trig_q[3];
  assign s_a = trig_q[4];
  assign c_a = trig_q[5];
  assign s_b = trig_q[6];
  assign c_b = trig_q[7];
  assign cj2 = val_t'(cj) + val_t'(32768);

  // Phase select for the table lookup
  logic [9:0]               phase_field;
  logic [PHASE_BITS+9:0]    phase_ext;
  logic [PHASE_BITS-1:0]    phase_sel;
  sin_t                     trig_val;
  always_comb begin
    case (kcnt_q[2:1])
      2'd0:    phase_field = tube_q;
      2'd1:    phase_field = ring_q;
      2'd2:    phase_field = angle_a_q;
      default: phase_field = angle_b_q;
    endcase
    phase_ext = {PHASE_BITS'(0), phase_field};
    phase_sel = phase_ext[PHASE_BITS-1:0]
              + (kcnt_q[0] ? PHASE_BITS'(QUART) : PHASE_BITS'(0));
  end

  tpz_trig #(.PHASE_BITS(PHASE_BITS)) u_trig (
    .phase_i (phase_sel),
    .value_o (trig_val)
  );

  // Operand select of the shared multiplier
  logic signed [26:0] mul_a, mul_b;
  logic signed [53:0] mul_full;
  val_t               mul_v;
  always_comb begin
    unique case (step_q)
      MS_SICJ2: begin mul_a = 27'(si);      mul_b = 27'(cj2); end
      MS_CICJ2: begin mul_a = 27'(ci);      mul_b = 27'(cj2); end
      MS_D1:    begin mul_a = 27'(sicj2_q); mul_b = 27'(s_a); end
      MS_D2:    begin mul_a = 27'(sj);      mul_b = 27'(c_a); end
      MS_T1:    begin mul_a = 27'(sicj2_q); mul_b = 27'(c_a); end
      MS_T2:    begin mul_a = 27'(sj);      mul_b = 27'(s_a); end
      MS_X1:    begin mul_a = 27'(cicj2_q); mul_b = 27'(c_b); end
      MS_X2:    begin mul_a = 27'(tacc_q);  mul_b = 27'(s_b); end
      MS_Y1:    begin mul_a = 27'(cicj2_q); mul_b = 27'(s_b); end
      MS_Y2:    begin mul_a = 27'(tacc_q);  mul_b = 27'(c_b); end
      MS_SICJ:  begin mul_a = 27'(si);      mul_b = 27'(cj);  end
      MS_CICJ:  begin mul_a = 27'(ci);      mul_b = 27'(cj);  end
      MS_U:     begin mul_a = 27'(sicj_q);  mul_b = 27'(c_a); end
      MS_L1:    begin mul_a = 27'(uacc_q);  mul_b = 27'(c_b); end
      MS_L2:    begin mul_a = 27'(sicj_q);  mul_b = 27'(s_a); end
      MS_L3:    begin mul_a = 27'(cicj_q);  mul_b = 27'(s_b); end
      MS_XW:    begin mul_a = 27'(SCREEN_WIDTH / 4);  mul_b = 27'(xacc_q); end
      MS_XP:    begin mul_a = xw_q;         mul_b = 27'({1'b0, depth_q}); end
      MS_YW:    begin mul_a = 27'(SCREEN_HEIGHT / 4); mul_b = 27'(yacc_q); end
      MS_YP:    begin mul_a = yw_q;         mul_b = 27'({1'b0, depth_q}); end
      default:  begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  tpz_mul u_mul (
    .clk_i    (clk_i),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .full_o   (mul_full),
    .scaled_o (mul_v)
  );

  // Frame stores
  frame_ctl_t        fctl;
  logic [15:0]       rd_depth;
  logic [6:0]        rd_glyph;
  logic              fbusy;
  logic              plot_hit;
  logic              in_beat;
  assign in_beat  = in_i.valid && in_i.ready;
  assign plot_hit = depth_q > rd_depth;

  always_comb begin
    fctl.clr_start = in_beat && (in_i.operation == OP_CLEAR);
    fctl.rd_en     = (state_q == ST_RDREQ);
    fctl.wr_en     = (state_q == ST_CMP) && (op_q == OP_PLOT) && plot_hit;
  end

  tpz_frame #(.PIX_COUNT(PIX_COUNT), .ADDR_W(ADDR_W)) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (fctl),
    .addr_i     (addr_q),
    .wr_depth_i (depth_q),
    .wr_glyph_i (shade_q),
    .rd_depth_o (rd_depth),
    .rd_glyph_o (rd_glyph),
    .busy_o     (fbusy)
  );

  // Position, divider and shade helpers
  logic signed [55:0] xsum, ysum, xadj, yadj;
  logic signed [20:0] deff;
  logic [19:0]        rem2;
  logic               div_ge;
  logic [3:0]         shade_n;
  logic               on_screen;
  logic               read_in_range;
  val_t               lum_shift;
  always_comb begin
    xsum = X_BIAS + 56'(xprod_q);
    ysum = Y_BIAS + 56'(yprod_q);
    xadj = xsum + (xsum[55] ? 56'sd1073741823 : 56'sd0);
    yadj = ysum + (ysum[55] ? 56'sd1073741823 : 56'sd0);
    deff = 21'(dacc_q) + 21'sd81920;
    rem2 = {rem_q[18:0], 1'b0};
    div_ge = rem2 >= dvs_q;
    lum_shift = lacc_q >>> 11;
    if (lacc_q[19])                   shade_n = 4'd0;
    else if (lum_shift > val_t'(11))  shade_n = 4'd11;
    else                              shade_n = lum_shift[3:0];
    on_screen = !x_q[25] && (x_q < 26'(SCREEN_WIDTH))
             && !y_q[25] && (y_q < 26'(SCREEN_HEIGHT));
    read_in_range = 32'(in_i.read_index) < PIX_COUNT;
  end

  // Config registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_a_q <= '0;
      angle_b_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_ANGLE_A) angle_a_q <= cfg_i.data;
      if (cfg_i.index == CFG_ANGLE_B) angle_b_q <= cfg_i.data;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE) && !fbusy;

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= MS_SICJ2;
      kcnt_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            kcnt_q <= '0;
            step_q <= MS_SICJ2;
            case (in_i.operation)
              OP_CLEAR: state_q <= ST_CLEAR;
              OP_PLOT:  state_q <= ST_TRIG;
              OP_READ:  state_q <= read_in_range ? ST_RDREQ : ST_DONE;
              default:  state_q <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: if (!fbusy) state_q <= ST_DONE;
        ST_TRIG: begin
          kcnt_q <= kcnt_q + 1'b1;
          if (kcnt_q == 3'd7) state_q <= ST_MISS;
        end
        ST_MISS: state_q <= ST_MWB;
        ST_MWB: begin
          step_q <= step_q + 1'b1;
          if (step_q == MS_L3)      state_q <= ST_DIVSET;
          else if (step_q == MS_YP) state_q <= ST_POS;
          else                      state_q <= ST_MISS;
        end
        ST_DIVSET: begin
          div_cnt_q <= '0;
          state_q   <= (deff <= 21'sd16384) ? ST_MISS : ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 4'd15) state_q <= ST_MISS;
        end
        ST_POS:   state_q <= ST_ADDR;
        ST_ADDR:  state_q <= on_screen ? ST_RDREQ : ST_DONE;
        ST_RDREQ: state_q <= ST_CMP;
        ST_CMP:   state_q <= ST_DONE;
        ST_DONE:  if (!out_valid_q || out_o.ready) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        op_q      <= in_i.operation;
        tube_q    <= in_i.tube_phase;
        ring_q    <= in_i.ring_phase;
        addr_q    <= ADDR_W'(in_i.read_index);
        res_pix_q <= (in_i.operation == OP_READ) ? in_i.read_index : '0;
        res_gl_q  <= GLYPH_SPACE;
        res_hit_q <= 1'b0;
        res_dep_q <= '0;
      end
      ST_TRIG: trig_q[kcnt_q] <= trig_val;
      ST_MWB: begin
        case (step_q)
          MS_SICJ2: sicj2_q <= mul_v;
          MS_CICJ2: cicj2_q <= mul_v;
          MS_D1:    dacc_q  <= mul_v;
          MS_D2:    begin p2_q <= mul_v; dacc_q <= dacc_q + mul_v; end
          MS_T1:    tacc_q  <= mul_v;
          MS_T2:    begin p4_q <= mul_v; tacc_q <= tacc_q - mul_v; end
          MS_X1:    xacc_q  <= mul_v;
          MS_X2:    xacc_q  <= xacc_q - mul_v;
          MS_Y1:    yacc_q  <= mul_v;
          MS_Y2:    yacc_q  <= yacc_q + mul_v;
          MS_SICJ:  sicj_q  <= mul_v;
          MS_CICJ:  cicj_q  <= mul_v;
          MS_U:     uacc_q  <= p4_q - mul_v;
          MS_L1:    lacc_q  <= mul_v;
          MS_L2:    lacc_q  <= lacc_q - mul_v - p2_q;
          MS_L3:    lacc_q  <= lacc_q - mul_v;
          MS_XW:    xw_q    <= mul_full[26:0];
          MS_XP:    xprod_q <= mul_full;
          MS_YW:    yw_q    <= mul_full[26:0];
          MS_YP:    yprod_q <= mul_full;
          default:  ;
        endcase
      end
      ST_DIVSET: begin
        dvs_q   <= 20'(deff);
        rem_q   <= 20'd16384;
        depth_q <= (deff <= 21'sd16384) ? 16'hffff : 16'h0000;
      end
      ST_DIV: begin
        rem_q   <= div_ge ? (rem2 - dvs_q) : rem2;
        depth_q <= {depth_q[14:0], div_ge};
      end
      ST_POS: begin
        x_q     <= 26'(xadj >>> 30);
        y_q     <= 26'(yadj >>> 30);
        shade_q <= shade_glyph(shade_n);
      end
      ST_ADDR: begin
        addr_q    <= ADDR_W'(x_q[8:0]) + ADDR_W'(SCREEN_WIDTH * y_q[7:0]);
        res_dep_q <= depth_q;
      end
      ST_CMP: begin
        res_pix_q <= 11'(addr_q);
        if (op_q == OP_PLOT) begin
          res_hit_q <= plot_hit;
          res_gl_q  <= plot_hit ? shade_q : rd_glyph;
        end else begin
          res_gl_q  <= rd_glyph;
          res_dep_q <= rd_depth;
        end
      end
      default: ;
    endcase
  end

  // Result register: load on finish, drop on the out beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && (!out_valid_q || out_o.ready)) begin
      out_pix_q <= res_pix_q;
      out_gl_q  <= res_gl_q;
      out_hit_q <= res_hit_q;
      out_dep_q <= res_dep_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_index = out_pix_q;
  assign out_o.glyph       = out_gl_q;
  assign out_o.plotted     = out_hit_q;
  assign out_o.depth_value = out_dep_q;
endmodule
`default_nettype wire

// ===== test/tpz_plot_checker.sv =====
// Checker for the torus point z-buffer plotter: watches the input, config and
// result channels, predicts every result and compares. Depends on tpz_pkg, tpz_ifs.
`timescale 1ns / 1ps
module tpz_plot_checker import tpz_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpz_in_if         in_c,
  tpz_out_if        out_c,
  tpz_cfg_if        cfg_c,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int unsigned PIX_COUNT = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF;
  localparam longint      ONE_Q14   = 16384;
  localparam longint      ONE_Q30   = 64'd1 << 30;

  typedef struct packed {
    logic [FIELD_INDEX_W-1:0] pixel_index;
    logic [GLYPH_W-1:0]       glyph;
    logic                     plotted;
    logic [DEPTH_W-1:0]       depth_value;
  } pixel_beat_t;

  logic [9:0]         rot_a;
  logic [9:0]         rot_b;
  logic [DEPTH_W-1:0] zbuf [PIX_COUNT];
  logic [GLYPH_W-1:0] frame[PIX_COUNT];
  pixel_beat_t        pixels_due[$];
  int                 fails;
  int                 n_due;

  assign fail_count_o = fails;
  assign pending_o    = n_due;

  // Quarter-wave polynomial sine, u in 0..4096, Q14 out
  function automatic longint quad_sine(input longint unsigned u);
    longint unsigned z, z2, c3, c2, s, r;
    z  = u << 18;
    z2 = (z * z) >> 30;
    c3 = POLY_B - ((z2 * POLY_C) >> 30);
    c2 = POLY_A - ((z2 * c3) >> 30);
    s  = (z * c2) >> 30;
    r  = (s + 32768) >> 16;
    if (r > 16384) r = 16384;
    return longint'(r);
  endfunction

  function automatic longint phase_sine(input logic [9:0] ph);
    logic [13:0] p;
    longint      v;
    p = {ph, 4'b0000};
    v = p[12] ? quad_sine(4096 - p[11:0]) : quad_sine(p[11:0]);
    return p[13] ? -v : v;
  endfunction

  function automatic longint phase_cosine(input logic [9:0] ph);
    return phase_sine(ph + 10'd256);
  endfunction

  // Q14 product, truncated toward zero
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) / ONE_Q14;
  endfunction

  function automatic logic [GLYPH_W-1:0] ramp_char(input longint n);
    string ramp;
    byte   c;
    ramp = ".,-~:;=!*#$@";
    c    = ramp[n];
    return c[GLYPH_W-1:0];
  endfunction

  // Work out one result and update the frame copy
  task automatic predict_pixel(input logic [1:0] op, input logic [9:0] tp,
                               input logic [9:0] rp, input logic [10:0] ri,
                               output pixel_beat_t res);
    longint sj, cj, si, ci, sa, ca, sb, cb, cj2, sicj2, cicj2, dv, tt, xs, ys;
    longint sicj, lum, dep, x, y, n, o;
    res = '{pixel_index: '0, glyph: GLYPH_SPACE, plotted: 1'b0, depth_value: '0};
    case (op)
      OP_CLEAR: begin
        for (int k = 0; k < PIX_COUNT; k++) begin
          zbuf[k]  = '0;
          frame[k] = GLYPH_SPACE;
        end
      end
      OP_PLOT: begin
        sj = phase_sine(tp); cj = phase_cosine(tp);
        si = phase_sine(rp); ci = phase_cosine(rp);
        sa = phase_sine(rot_a); ca = phase_cosine(rot_a);
        sb = phase_sine(rot_b); cb = phase_cosine(rot_b);
        cj2   = cj + 2 * ONE_Q14;
        sicj2 = qmul(si, cj2);
        cicj2 = qmul(ci, cj2);
        dv    = qmul(sicj2, sa) + qmul(sj, ca) + 5 * ONE_Q14;
        tt    = qmul(sicj2, ca) - qmul(sj, sa);
        xs    = qmul(cicj2, cb) - qmul(tt, sb);
        ys    = qmul(cicj2, sb) + qmul(tt, cb);
        sicj  = qmul(si, cj);
        lum   = qmul(qmul(sj, sa) - qmul(sicj, ca), cb) - qmul(sicj, sa)
                - qmul(sj, ca) - qmul(qmul(ci, cj), sb);
        if (dv < 1) dv = 1;
        dep = ONE_Q30 / dv;
        if (dep > 65535) dep = 65535;
        x = (longint'(SCREEN_WIDTH_DEF / 2) * ONE_Q30
             + longint'(SCREEN_WIDTH_DEF / 4) * dep * xs) / ONE_Q30;
        y = (longint'(SCREEN_HEIGHT_DEF / 2) * ONE_Q30
             + longint'(SCREEN_HEIGHT_DEF / 4) * dep * ys) / ONE_Q30;
        n = (8 * lum) / ONE_Q14;
        if (n < 0) n = 0;
        if (n > 11) n = 11;
        res.depth_value = dep[DEPTH_W-1:0];
        if (x >= 0 && x < SCREEN_WIDTH_DEF && y >= 0 && y < SCREEN_HEIGHT_DEF) begin
          o = x + longint'(SCREEN_WIDTH_DEF) * y;
          if (dep > longint'(zbuf[o])) begin
            zbuf[o]     = dep[DEPTH_W-1:0];
            frame[o]    = ramp_char(n);
            res.plotted = 1'b1;
          end
          res.pixel_index = o[FIELD_INDEX_W-1:0];
          res.glyph       = frame[o];
        end
      end
      OP_READ: begin
        res.pixel_index = ri;
        if (ri < PIX_COUNT) begin
          res.glyph       = frame[ri];
          res.depth_value = zbuf[ri];
        end
      end
      default: ;
    endcase
  endtask

  // Track registers, predict on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t want;
    pixel_beat_t got;
    if (!rst_ni) begin
      rot_a = '0;
      rot_b = '0;
      fails = 0;
      pixels_due.delete();
      for (int k = 0; k < PIX_COUNT; k++) begin
        zbuf[k]  = '0;
        frame[k] = GLYPH_SPACE;
      end
    end else begin
      if (cfg_c.valid && cfg_c.ready) begin
        if (cfg_c.index == CFG_ANGLE_A) rot_a = cfg_c.data;
        else if (cfg_c.index == CFG_ANGLE_B) rot_b = cfg_c.data;
      end
      if (out_c.valid && out_c.ready) begin
        got = '{pixel_index: out_c.pixel_index, glyph: out_c.glyph,
                plotted: out_c.plotted, depth_value: out_c.depth_value};
        if (pixels_due.size() == 0) begin
          $error("result beat with nothing expected: %p", got);
          fails++;
        end else begin
          want = pixels_due.pop_front();
          if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
            fails++;
          end
          if (got.glyph !== want.glyph) begin
            $error("glyph: expected %0d, got %0d", want.glyph, got.glyph);
            fails++;
          end
          if (got.plotted !== want.plotted) begin
            $error("plotted: expected %0d, got %0d", want.plotted, got.plotted);
            fails++;
          end
          if (got.depth_value !== want.depth_value) begin
            $error("depth_value: expected %0d, got %0d", want.depth_value, got.depth_value);
            fails++;
          end
        end
      end
      if (in_c.valid && in_c.ready) begin
        predict_pixel(in_c.operation, in_c.tube_phase, in_c.ring_phase, in_c.read_index,
                      want);
        pixels_due.push_back(want);
      end
    end
    n_due = pixels_due.size();
  end

endmodule

// ===== test/tb_torus_point_zbuffer_plotter_top.sv =====
// Testbench top for the torus point z-buffer plotter: clock, reset, stimulus
// and verdict. Depends on tpz_pkg, tpz_ifs, the plotter top and tpz_plot_checker.
`timescale 1ns / 1ps
module tb_torus_point_zbuffer_plotter_top;
  import tpz_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;
  int   beats_in;
  bit   squeeze_done;

  tpz_in_if  in_ch();
  tpz_out_if out_ch();
  tpz_cfg_if cfg_ch();

  torus_point_zbuffer_plotter_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  tpz_plot_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_c        (in_ch),
    .out_c       (out_ch),
    .cfg_c       (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Run-length guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off while input keeps coming
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!squeeze_done && beats_in >= 150) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
    end
  end

  // Offer one beat, return at the edge where it is taken
  task automatic send_point(input logic [1:0] op, input logic [9:0] tp,
                            input logic [9:0] rp, input logic [10:0] ri);
    int  g;
    bit  ok;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.tube_phase <= tp;
    in_ch.ring_phase <= rp;
    in_ch.read_index <= ri;
    do begin
      @(negedge clk_i);
      ok = in_ch.ready;
      @(posedge clk_i);
    end while (!ok);
    beats_in++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] val);
    bit ok;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(negedge clk_i);
      ok = cfg_ch.ready;
      @(posedge clk_i);
    end while (!ok);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain, then let the block settle before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_burst(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 78)
        send_point(OP_PLOT, 10'($urandom), 10'($urandom), 11'($urandom));
      else if (r < 92)
        send_point(OP_READ, 10'($urandom), 10'($urandom), 11'($urandom_range(0, 1759)));
      else if (r < 95)
        send_point(OP_READ, 10'($urandom), 10'($urandom), 11'($urandom_range(1760, 2047)));
      else if (r < 97)
        send_point(OP_CLEAR, 10'($urandom), 10'($urandom), 11'($urandom));
      else
        send_point(OP_UNUSED, 10'($urandom), 10'($urandom), 11'($urandom));
    end
  endtask

  initial begin
    beats_in         = 0;
    rst_ni           = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_CLEAR;
    in_ch.tube_phase <= '0;
    in_ch.ring_phase <= '0;
    in_ch.read_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_ANGLE_A;
    cfg_ch.data      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads of a fresh frame, phase extremes, clear, unused code
    send_point(OP_READ, '0, '0, 11'd0);
    send_point(OP_READ, '0, '0, 11'd1759);
    send_point(OP_READ, '0, '0, 11'd1760);
    send_point(OP_READ, '0, '0, 11'd2047);
    send_point(OP_PLOT, 10'd0, 10'd0, '0);
    send_point(OP_PLOT, 10'd0, 10'd0, '0);
    send_point(OP_PLOT, 10'd1023, 10'd1023, 11'd2047);
    send_point(OP_PLOT, 10'd256, 10'd512, '0);
    send_point(OP_PLOT, 10'd512, 10'd768, '0);
    send_point(OP_PLOT, 10'd768, 10'd256, '0);
    send_point(OP_PLOT, 10'd255, 10'd257, '0);
    send_point(OP_PLOT, 10'd1023, 10'd0, '0);
    send_point(OP_READ, '0, '0, 11'd920);
    send_point(OP_UNUSED, 10'd1023, 10'd1023, 11'd2047);
    send_point(OP_CLEAR, '0, '0, '0);
    send_point(OP_READ, '0, '0, 11'd920);
    send_point(OP_PLOT, 10'd100, 10'd300, '0);
    send_point(OP_PLOT, 10'd100, 10'd300, '0);
    random_burst(100);
    drain();

    // Extreme angles
    write_reg(CFG_ANGLE_A, 10'd1023);
    write_reg(CFG_ANGLE_B, 10'd1023);
    random_burst(110);
    drain();

    write_reg(CFG_ANGLE_A, 10'd256);
    write_reg(CFG_ANGLE_B, 10'd512);
    random_burst(100);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      write_reg(CFG_ANGLE_A, 10'($urandom));
      write_reg(CFG_ANGLE_B, 10'($urandom));
      random_burst(110);
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tpz_pkg.sv
rtl/tpz_ifs.sv
rtl/tpz_trig.sv
rtl/tpz_mul.sv
rtl/tpz_frame.sv
rtl/torus_point_zbuffer_plotter_top.sv
test/tpz_plot_checker.sv
test/tb_torus_point_zbuffer_plotter_top.sv
